// ===== rtl/rcm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter package
// Field widths, register codes, reset values, scaling constants and the
// command, status, payload and state types shared by the meter modules.
// ----------------------------------------------------------------------------
package rcm_pkg;

   localparam int SAMPLE_W            = 10;
   localparam int SAMPLE_BITS_DEFAULT = 10;
   localparam int MID_W               = 10;
   localparam int OFFSET_W            = 10;
   localparam int MS_W                = 8;
   localparam int READING_W           = 12;
   localparam int SUM_W               = 32;
   localparam int TOTAL_W             = 12;
   localparam int ROOT_W              = 16;
   localparam int CROSS_W             = 2;
   localparam int CSR_INDEX_W         = 2;
   localparam int CSR_DATA_W          = 10;

   localparam int DIV_STEPS  = SUM_W;
   localparam int ROOT_STEPS = SUM_W / 2;
   localparam int CNT_W      = $clog2(DIV_STEPS);

   localparam int SCALE_NUM   = 954;
   localparam int SCALE_DEN   = 1000;
   localparam int SCALE_NUM_W = 10;
   localparam int MUL_W       = ROOT_W + SCALE_NUM_W;
   localparam int RECIP_W     = 21;
   localparam int RECIP_SHIFT = 30;
   localparam int PROD_W      = MUL_W + RECIP_W;
   localparam int REM_W       = 11;
   localparam int SUMX_W      = ROOT_W + 2;

   localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / SCALE_DEN);

   localparam logic [MID_W-1:0]    MID_LEVEL_RESET      = MID_W'(512);
   localparam logic [OFFSET_W-1:0] READING_OFFSET_RESET = '0;
   localparam logic [MS_W-1:0]     WINDOW_MS_RESET      = MS_W'(35);
   localparam logic [MS_W-1:0]     DEBOUNCE_MS_RESET    = MS_W'(5);

   localparam logic [CROSS_W-1:0] CROSS_FIRST  = CROSS_W'(1);
   localparam logic [CROSS_W-1:0] CROSS_SECOND = CROSS_W'(2);
   localparam logic [CROSS_W-1:0] CROSS_THIRD  = CROSS_W'(3);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_MID_LEVEL      = 2'd0,
      CSR_READING_OFFSET = 2'd1,
      CSR_WINDOW_MS      = 2'd2,
      CSR_DEBOUNCE_MS    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic                start_flag;
      logic [SAMPLE_W-1:0] sample;
      logic [MS_W-1:0]     elapsed_ms;
   } req_type;

   typedef struct packed {
      logic signed [READING_W-1:0] reading;
      logic                        timed_out;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RUN,
      ST_DIVIDE,
      ST_ROOT_LOAD,
      ST_ROOT,
      ST_SCALE_MUL,
      ST_SCALE_RECIP,
      ST_SCALE_REM,
      ST_SCALE_OUT
   } state_type;

   typedef struct packed {
      logic accum;
      logic load_timeout;
      logic div_init;
      logic div_step;
      logic root_init;
      logic root_step;
      logic scale_mul;
      logic scale_recip;
      logic scale_rem;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic timeout;
      logic third;
      logic div_last;
      logic root_last;
      logic rsp_free;
   } status_type;

endpackage
`default_nettype wire

// ===== rtl/rcm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter controller
// Sequences sample intake, the divide and root iterations and the scaling
// steps, and gates the input channel.
// ----------------------------------------------------------------------------
module rcm_ctrl (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_start,
   input  wire rcm_pkg::status_type status,
   output rcm_pkg::cmd_type        cmd,
   output logic                    req_stall
);
   import rcm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      take_word;
   logic      active_eff;

   assign req_stall  = !(state_ff inside {ST_IDLE, ST_RUN}) || !status.rsp_free;
   assign take_word  = req_valid && !req_stall;
   assign active_eff = req_start || (state_ff == ST_RUN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE, ST_RUN: begin
            if (take_word && active_eff) begin
               if (status.timeout) begin
                  state_in = ST_IDLE;
               end else if (status.third) begin
                  state_in = ST_DIVIDE;
               end else begin
                  state_in = ST_RUN;
               end
            end
         end
         ST_DIVIDE: begin
            if (status.div_last) begin
               state_in = ST_ROOT_LOAD;
            end
         end
         ST_ROOT_LOAD: state_in = ST_ROOT;
         ST_ROOT: begin
            if (status.root_last) begin
               state_in = ST_SCALE_MUL;
            end
         end
         ST_SCALE_MUL:   state_in = ST_SCALE_RECIP;
         ST_SCALE_RECIP: state_in = ST_SCALE_REM;
         ST_SCALE_REM:   state_in = ST_SCALE_OUT;
         ST_SCALE_OUT: begin
            if (status.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE, ST_RUN: begin
            if (take_word && active_eff) begin
               if (status.timeout) begin
                  cmd.load_timeout = 1'b1;
               end else begin
                  cmd.accum    = 1'b1;
                  cmd.div_init = status.third;
               end
            end
         end
         ST_DIVIDE:      cmd.div_step    = 1'b1;
         ST_ROOT_LOAD:   cmd.root_init   = 1'b1;
         ST_ROOT:        cmd.root_step   = 1'b1;
         ST_SCALE_MUL:   cmd.scale_mul   = 1'b1;
         ST_SCALE_RECIP: cmd.scale_recip = 1'b1;
         ST_SCALE_REM:   cmd.scale_rem   = 1'b1;
         ST_SCALE_OUT:   cmd.load_result = status.rsp_free;
         default:        cmd = '0;
      endcase
   end

   a_busy_stalls: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE && state_ff != ST_RUN) |-> req_stall)
      else $error("word taken while the result is being computed");

endmodule
`default_nettype wire

// ===== rtl/rcm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter datapath
// Configuration registers, crossing detection, square accumulation,
// restoring divider, digit-by-digit square root, scaling and result register.
// ----------------------------------------------------------------------------
module rcm_datapath #(
   parameter int SAMPLE_BITS = rcm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rcm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rcm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire rcm_pkg::req_type                  req_data,
   input  wire rcm_pkg::cmd_type                  cmd,
   input  wire logic                              rsp_stall,
   output rcm_pkg::status_type                    status,
   output logic                                   rsp_valid,
   output rcm_pkg::rsp_type                       rsp_data
);
   import rcm_pkg::*;

   localparam int USE_BITS = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - USE_BITS);

   // configuration
   logic [MID_W-1:0]    mid_ff;
   logic [OFFSET_W-1:0] offset_ff;
   logic [MS_W-1:0]     window_ff;
   logic [MS_W-1:0]     debounce_ff;

   // measurement state
   logic               have_prev_ff, have_prev_in;
   logic               prev_above_ff, prev_above_in;
   logic [CROSS_W-1:0] cross_ff, cross_in;
   logic [MS_W-1:0]    last_ff, last_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   // iteration units
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [SUM_W-1:0]   quo_ff, quo_in;
   logic [TOTAL_W-1:0] rem_ff, rem_in;
   logic [SUM_W-1:0]   rv_ff, rv_in;
   logic [SUM_W-1:0]   root_ff, root_in;
   logic [SUM_W-1:0]   rbit_ff, rbit_in;

   // scaling
   logic [MUL_W-1:0]   scl_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [ROOT_W-1:0]  q0_ff;
   logic [REM_W-1:0]   rem0_ff;

   // result
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // status
   logic    timeout_hit;
   logic    third_hit;
   logic    div_last;
   logic    root_last;
   logic    rsp_free;

   // sample path
   logic [SAMPLE_W-1:0]        smp;
   logic                       above;
   logic                       have_prev_eff, prev_above_eff;
   logic [CROSS_W-1:0]         cross_eff, cross_new;
   logic [MS_W-1:0]            last_eff, gap;
   logic [SUM_W-1:0]           sum_eff;
   logic [TOTAL_W-1:0]         total_eff;
   logic                       counted;
   logic                       in_window;
   logic signed [SAMPLE_W:0]   diff;
   logic signed [2*SAMPLE_W+1:0] sq;

   // divider and root step
   logic [TOTAL_W:0]   div_shift;
   logic               div_fit;
   logic [SUM_W-1:0]   root_try;
   logic               root_fit;

   // scaling stages
   logic [MUL_W-1:0]         q0_by_den;
   logic                     rem_ge;
   logic [ROOT_W-1:0]        q_fix;
   logic                     rem_nz;
   logic signed [SUMX_W-1:0] sum_x;
   logic signed [SUMX_W-1:0] x_val;
   logic signed [READING_W-1:0] x_sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff      <= MID_LEVEL_RESET;
         offset_ff   <= READING_OFFSET_RESET;
         window_ff   <= WINDOW_MS_RESET;
         debounce_ff <= DEBOUNCE_MS_RESET;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_MID_LEVEL:      mid_ff      <= csr_wdata[MID_W-1:0];
            CSR_READING_OFFSET: offset_ff   <= csr_wdata[OFFSET_W-1:0];
            CSR_WINDOW_MS:      window_ff   <= csr_wdata[MS_W-1:0];
            CSR_DEBOUNCE_MS:    debounce_ff <= csr_wdata[MS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // crossing detection with the start word folding in a cleared state
   always_comb begin
      smp            = req_data.sample & SAMPLE_MASK;
      above          = smp > SAMPLE_W'(mid_ff);
      have_prev_eff  = req_data.start_flag ? 1'b0 : have_prev_ff;
      prev_above_eff = req_data.start_flag ? 1'b0 : prev_above_ff;
      cross_eff      = req_data.start_flag ? '0 : cross_ff;
      last_eff       = req_data.start_flag ? '0 : last_ff;
      sum_eff        = req_data.start_flag ? '0 : sum_ff;
      total_eff      = req_data.start_flag ? '0 : total_ff;
      gap            = req_data.elapsed_ms - last_eff;
      counted        = have_prev_eff && (above != prev_above_eff)
                       && ((cross_eff == '0) || (gap > debounce_ff));
      cross_new      = counted ? cross_eff + CROSS_W'(1) : cross_eff;
      in_window      = (cross_new == CROSS_FIRST) || (cross_new == CROSS_SECOND);
      diff           = $signed({1'b0, smp}) - $signed({1'b0, SAMPLE_W'(mid_ff)});
      sq             = diff * diff;

      timeout_hit    = req_data.elapsed_ms >= window_ff;
      third_hit      = cross_new == CROSS_THIRD;

      have_prev_in  = have_prev_ff;
      prev_above_in = prev_above_ff;
      cross_in      = cross_ff;
      last_in       = last_ff;
      sum_in        = sum_ff;
      total_in      = total_ff;
      if (cmd.accum) begin
         have_prev_in  = 1'b1;
         prev_above_in = above;
         cross_in      = cross_new;
         last_in       = counted ? req_data.elapsed_ms : last_eff;
         sum_in        = in_window ? sum_eff + SUM_W'($unsigned(sq)) : sum_eff;
         total_in      = (in_window && (total_eff != '1)) ? total_eff + TOTAL_W'(1)
                                                          : total_eff;
      end
   end

   // restoring divide and digit-by-digit root, one step a cycle
   always_comb begin
      div_shift = {rem_ff, quo_ff[SUM_W-1]};
      div_fit   = div_shift >= {1'b0, total_ff};
      root_try  = root_ff + rbit_ff;
      root_fit  = rv_ff >= root_try;

      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      rv_in   = rv_ff;
      root_in = root_ff;
      rbit_in = rbit_ff;
      if (cmd.div_init) begin
         cnt_in = '0;
         quo_in = sum_ff;
         rem_in = '0;
      end else if (cmd.div_step) begin
         cnt_in = cnt_ff + CNT_W'(1);
         quo_in = {quo_ff[SUM_W-2:0], div_fit};
         rem_in = div_fit ? TOTAL_W'(div_shift - {1'b0, total_ff})
                          : div_shift[TOTAL_W-1:0];
      end else if (cmd.root_init) begin
         cnt_in  = '0;
         rv_in   = (total_ff == '0) ? '0 : quo_ff;
         root_in = '0;
         rbit_in = SUM_W'(1) << (SUM_W - 2);
      end else if (cmd.root_step) begin
         cnt_in  = cnt_ff + CNT_W'(1);
         rv_in   = root_fit ? rv_ff - root_try : rv_ff;
         root_in = root_fit ? (root_ff >> 1) + rbit_ff : root_ff >> 1;
         rbit_in = rbit_ff >> 2;
      end
      div_last  = cnt_ff == CNT_W'(DIV_STEPS - 1);
      root_last = cnt_ff == CNT_W'(ROOT_STEPS - 1);
   end

   // scale by 954/1000 and add the offset, truncating toward zero
   always_comb begin
      q0_by_den = MUL_W'(prod_ff[RECIP_SHIFT +: ROOT_W]) * MUL_W'(SCALE_DEN);
      rem_ge    = rem0_ff >= REM_W'(SCALE_DEN);
      q_fix     = q0_ff + ROOT_W'(rem_ge);
      rem_nz    = rem_ge ? (rem0_ff != REM_W'(SCALE_DEN)) : (rem0_ff != '0);
      sum_x     = SUMX_W'($signed(offset_ff)) + $signed({2'b00, q_fix});
      x_val     = ((sum_x < 0) && rem_nz) ? sum_x + SUMX_W'(1) : sum_x;
      if (x_val > SUMX_W'(2 ** (READING_W - 1) - 1)) begin
         x_sat = {1'b0, {(READING_W - 1){1'b1}}};
      end else if (x_val < -SUMX_W'(2 ** (READING_W - 1))) begin
         x_sat = {1'b1, {(READING_W - 1){1'b0}}};
      end else begin
         x_sat = x_val[READING_W-1:0];
      end
   end

   // result register
   always_comb begin
      rsp_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;
      if (cmd.load_timeout) begin
         rsp_valid_in     = 1'b1;
         rsp_in.reading   = '0;
         rsp_in.timed_out = 1'b1;
      end else if (cmd.load_result) begin
         rsp_valid_in     = 1'b1;
         rsp_in.reading   = x_sat;
         rsp_in.timed_out = 1'b0;
      end
   end

   assign status = '{timeout:   timeout_hit,
                     third:     third_hit,
                     div_last:  div_last,
                     root_last: root_last,
                     rsp_free:  rsp_free};

   always_ff @(posedge clock) begin
      if (reset) begin
         have_prev_ff  <= 1'b0;
         prev_above_ff <= 1'b0;
         cross_ff      <= '0;
         last_ff       <= '0;
         sum_ff        <= '0;
         total_ff      <= '0;
         cnt_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         have_prev_ff  <= have_prev_in;
         prev_above_ff <= prev_above_in;
         cross_ff      <= cross_in;
         last_ff       <= last_in;
         sum_ff        <= sum_in;
         total_ff      <= total_in;
         cnt_ff        <= cnt_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      rv_ff   <= rv_in;
      root_ff <= root_in;
      rbit_ff <= rbit_in;
      rsp_ff  <= rsp_in;
      if (cmd.scale_mul) begin
         scl_ff <= MUL_W'(root_ff[ROOT_W-1:0]) * MUL_W'(SCALE_NUM);
      end
      if (cmd.scale_recip) begin
         prod_ff <= PROD_W'(scl_ff) * PROD_W'(RECIP);
      end
      if (cmd.scale_rem) begin
         q0_ff   <= prod_ff[RECIP_SHIFT +: ROOT_W];
         rem0_ff <= REM_W'(scl_ff - q0_by_den);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_result || cmd.load_timeout) |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result loaded over a word still waiting");

   a_div_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      cmd.div_step |-> ({1'b0, rem_ff} < {1'b0, total_ff}))
      else $error("divider remainder not below the sample count");

   a_root_fits: assert property (@(posedge clock) disable iff (reset)
      cmd.scale_mul |-> (root_ff[SUM_W-1:ROOT_W] == '0))
      else $error("square root wider than its field");

endmodule
`default_nettype wire

// ===== rtl/rms_current_meter_top.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// RMS current meter
// True-RMS current reading over a window framed by three zero crossings.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_data  (start_flag, sample, elapsed_ms)
//   rsp      out        rsp_valid/rsp_stall  rsp_data  (reading, timed_out)
//   csr      in         csr_we               csr_index, csr_wdata
//
// Samples are taken one per cycle while a measurement runs or the block idles.
// The word that brings the third crossing stalls the input through its
// 32 divider steps, one root load, 16 root steps and 4 scaling steps.
// A timeout result is ready the cycle after its word.
// The input also stalls while a result waits and rsp_stall is high.
// Reset loads the register defaults and ends any measurement; no clearing pass.
// ----------------------------------------------------------------------------
module rms_current_meter_top #(
   parameter int SAMPLE_BITS = rcm_pkg::SAMPLE_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [rcm_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [rcm_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire rcm_pkg::req_type                  req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output rcm_pkg::rsp_type                       rsp_data
);
   import rcm_pkg::*;

   cmd_type    cmd;
   status_type status;

   rcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_start (req_data.start_flag),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   rcm_datapath #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .cmd       (cmd),
      .rsp_stall (rsp_stall),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

// ===== tb/rms_current_meter_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RMS current meter testbench
// Sends a table of directed sample words and then random measurements,
// each a run of samples that swings around the mid level. The register
// settings change between phases, extremes among them. The testbench
// predicts each reading and timeout from its own model of the meter, or
// takes it from the directed table, and checks each result word against
// the oldest prediction, under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module rms_current_meter_top_test;
   import rcm_pkg::*;

   localparam int WATCHDOG_LIMIT = 4000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int PHASE_WORDS    = 150;
   localparam int PHASES         = 8;

   typedef struct packed {
      logic                 start;
      logic [9:0]           sample;
      logic [7:0]           ms;
      logic                 fixed;
      logic signed [11:0]   reading;
      logic                 timed_out;
   } directed_row_t;

   typedef struct packed {
      logic [9:0]           mid;
      logic signed [9:0]    off;
      logic [7:0]           win;
      logic [7:0]           deb;
   } setting_t;

   // Reset settings: mid 512, window 35, debounce 5.
   localparam directed_row_t DIRECTED [20] = '{
      '{1'b0, 10'd700,  8'd3,   1'b0, 12'sd0, 1'b0},
      '{1'b1, 10'd0,    8'd35,  1'b1, 12'sd0, 1'b1},
      '{1'b1, 10'd1023, 8'd0,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd0,    8'd1,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd1023, 8'd2,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd0,    8'd8,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd1023, 8'd10,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd0,    8'd14,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd300,  8'd15,  1'b0, 12'sd0, 1'b0},
      '{1'b1, 10'd512,  8'd0,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd513,  8'd0,   1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd512,  8'd34,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd512,  8'd255, 1'b1, 12'sd0, 1'b1},
      '{1'b1, 10'd1023, 8'd20,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd0,    8'd20,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd1023, 8'd10,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd0,    8'd30,  1'b0, 12'sd0, 1'b0},
      '{1'b1, 10'd0,    8'd34,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd1023, 8'd34,  1'b0, 12'sd0, 1'b0},
      '{1'b0, 10'd1023, 8'd35,  1'b1, 12'sd0, 1'b1}
   };

   localparam setting_t EXTREMES [4] = '{
      '{10'd512,  10'sd511,  8'd255, 8'd0},
      '{10'd0,    -10'sd512, 8'd255, 8'd255},
      '{10'd1023, 10'sd0,    8'd1,   8'd5},
      '{10'd300,  10'sd100,  8'd0,   8'd3}
   };

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0]  csr_index = CSR_MID_LEVEL;
   logic [CSR_DATA_W-1:0]   csr_wdata = '0;
   logic                    req_valid = 1'b0;
   logic                    req_stall;
   req_type                 req_data = '0;
   logic                    rsp_valid;
   logic                    rsp_stall = 1'b0;
   rsp_type                 rsp_data;

   // meter model state and registers
   logic                    meter_active = 1'b0;
   logic                    meter_have_prev = 1'b0;
   logic                    meter_prev_above = 1'b0;
   logic [1:0]              meter_crossings = '0;
   logic [7:0]              meter_last_ms = '0;
   logic [31:0]             meter_square_sum = '0;
   logic [11:0]             meter_sample_total = '0;
   logic [9:0]              cfg_mid = MID_LEVEL_RESET;
   logic signed [9:0]       cfg_offset = READING_OFFSET_RESET;
   logic [7:0]              cfg_window = WINDOW_MS_RESET;
   logic [7:0]              cfg_debounce = DEBOUNCE_MS_RESET;

   rsp_type                 pending_readings [$];
   rsp_type                 oldest_reading;
   int                      mismatches = 0;
   int                      sent_words = 0;
   int                      burst_left = 0;
   int                      idle_cycles = 0;
   logic [1:0]              stall_mode = '0;
   logic [8:0]              stall_tick = '0;

   rms_current_meter_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   function automatic logic [15:0] int_sqrt(input logic [31:0] v);
      logic [15:0] root;
      logic [15:0] trial;
      root = '0;
      for (int b = 15; b >= 0; b--) begin
         trial = root | (16'd1 << b);
         if (longint'(trial) * longint'(trial) <= longint'(v))
            root = trial;
      end
      return root;
   endfunction

   function automatic logic predict_reading(input req_type w, output rsp_type r);
      logic       above;
      logic [7:0] gap;
      logic [31:0] mean;
      int         diff;
      longint     x;
      r = '0;
      if (w.start_flag) begin
         meter_active = 1'b1;
         meter_have_prev = 1'b0;
         meter_prev_above = 1'b0;
         meter_crossings = '0;
         meter_last_ms = '0;
         meter_square_sum = '0;
         meter_sample_total = '0;
      end
      if (!meter_active)
         return 1'b0;
      if (w.elapsed_ms >= cfg_window) begin
         meter_active = 1'b0;
         r.timed_out = 1'b1;
         return 1'b1;
      end
      above = w.sample > cfg_mid;
      if (meter_have_prev && above != meter_prev_above) begin
         gap = w.elapsed_ms - meter_last_ms;
         if (meter_crossings == '0 || gap > cfg_debounce) begin
            meter_crossings = meter_crossings + 2'd1;
            meter_last_ms = w.elapsed_ms;
         end
      end
      meter_have_prev = 1'b1;
      meter_prev_above = above;
      if (meter_crossings == CROSS_FIRST || meter_crossings == CROSS_SECOND) begin
         diff = int'(w.sample) - int'(cfg_mid);
         meter_square_sum = meter_square_sum + 32'(diff * diff);
         if (meter_sample_total != 12'hFFF)
            meter_sample_total = meter_sample_total + 12'd1;
         return 1'b0;
      end
      if (meter_crossings == CROSS_THIRD) begin
         mean = (meter_sample_total != 0) ? meter_square_sum / 32'(meter_sample_total) : '0;
         x = (longint'(int_sqrt(mean)) * SCALE_NUM + longint'(cfg_offset) * SCALE_DEN)
            / SCALE_DEN;
         if (x > 2047)
            x = 2047;
         if (x < -2048)
            x = -2048;
         meter_active = 1'b0;
         r.reading = x[11:0];
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic write_reg(input csr_index_type idx, input logic [9:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_setting(input setting_t s);
      write_reg(CSR_MID_LEVEL, s.mid);
      write_reg(CSR_READING_OFFSET, s.off);
      write_reg(CSR_WINDOW_MS, {2'($urandom), s.win});
      write_reg(CSR_DEBOUNCE_MS, {2'($urandom), s.deb});
      csr_we <= 1'b0;
      cfg_mid = s.mid;
      cfg_offset = s.off;
      cfg_window = s.win;
      cfg_debounce = s.deb;
   endtask

   task automatic send_word(input req_type w, input logic fixed, input rsp_type typed);
      rsp_type r;
      logic    got;
      int      gap;
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) == 0) begin
            gap = 0;
            burst_left = $urandom_range(50, 150);
         end else begin
            gap = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 20);
         end
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      got = predict_reading(w, r);
      if (fixed)
         pending_readings.push_back(typed);
      else if (got)
         pending_readings.push_back(r);
      sent_words++;
   endtask

   // drain, then hold off for a result still being computed
   task automatic settle();
      req_valid <= 1'b0;
      burst_left = 0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_measurement();
      req_type w;
      int      n;
      int      hold;
      int      step;
      int      amp;
      int      delta;
      int      level;
      int      ms;
      logic    side;
      n = $urandom_range(6, 48);
      hold = $urandom_range(1, 6);
      step = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 16) : $urandom_range(1, 3);
      amp = ($urandom_range(0, 7) == 0) ? 1023 : $urandom_range(1, 511);
      side = 1'($urandom);
      ms = $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) begin
         w = {1'b0, 10'($urandom), 8'($urandom)};
         send_word(w, 1'b0, '0);
      end
      for (int i = 0; i < n; i++) begin
         if (i != 0 && i % hold == 0)
            side = !side;
         if (side) begin
            delta = $urandom_range(1, amp);
            level = int'(cfg_mid) + delta;
         end else begin
            delta = $urandom_range(0, amp);
            level = int'(cfg_mid) - delta;
         end
         if (level < 0)
            level = 0;
         if (level > 1023)
            level = 1023;
         w.start_flag = (i == 0);
         w.sample = level[9:0];
         w.elapsed_ms = ms[7:0];
         if ($urandom_range(0, 19) == 0) begin
            case ($urandom_range(0, 2))
               0: w.sample = 10'($urandom);
               1: w.elapsed_ms = 8'($urandom);
               default: w.start_flag = ~w.start_flag;
            endcase
         end
         send_word(w, 1'b0, '0);
         delta = $urandom_range(0, step);
         ms = ms + delta;
         if (ms > 255)
            ms = 255;
      end
   endtask

   task automatic flag_mismatch(input string what, input int want, input int got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch %s: expected %0d, actual %0d", what, want, got);
   endtask

   always @(posedge clock) begin
      stall_tick <= stall_tick + 9'd1;
      if (stall_tick == '0)
         stall_mode <= 2'($urandom);
      case (stall_mode)
         2'd0: rsp_stall <= 1'b0;
         2'd1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2'd2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= stall_tick[2];
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_readings.size() == 0) begin
            flag_mismatch("result with none pending, reading", 0, int'(rsp_data.reading));
         end else begin
            oldest_reading = pending_readings.pop_front();
            if (rsp_data.reading !== oldest_reading.reading)
               flag_mismatch("reading", int'(oldest_reading.reading),
                             int'(rsp_data.reading));
            if (rsp_data.timed_out !== oldest_reading.timed_out)
               flag_mismatch("timed_out", int'(oldest_reading.timed_out),
                             int'(rsp_data.timed_out));
         end
      end
   end

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   initial begin
      wait (idle_cycles >= WATCHDOG_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      req_type  w;
      rsp_type  typed;
      setting_t s;
      int       phase_start;
      @(posedge clock);
      while (reset) @(posedge clock);
      for (int i = 0; i < $size(DIRECTED); i++) begin
         w.start_flag = DIRECTED[i].start;
         w.sample = DIRECTED[i].sample;
         w.elapsed_ms = DIRECTED[i].ms;
         typed.reading = DIRECTED[i].reading;
         typed.timed_out = DIRECTED[i].timed_out;
         send_word(w, DIRECTED[i].fixed, typed);
      end
      for (int p = 0; p < PHASES; p++) begin
         settle();
         if (p % 2 == 1) begin
            s = EXTREMES[p / 2];
         end else begin
            s.mid = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(256, 767));
            s.off = 10'($urandom);
            s.win = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(20, 255));
            s.deb = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
         end
         apply_setting(s);
         phase_start = sent_words;
         while (sent_words - phase_start < PHASE_WORDS)
            run_measurement();
      end
      settle();
      if (mismatches == 0 && pending_readings.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
